// File: hw/rtl/plsc_pkg.sv
// Shared types, constants and the saturation helper of the sensor calibration unit.
`default_nettype none

package plsc_pkg;

    // Working width of the shared divider.
    localparam int DIV_W = 64;

    // Reciprocal for a truncating divide by 100 of a magnitude below 2**32.
    localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;
    localparam int          DIV100_SHIFT = 37;

    localparam int SCALE = 100;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic signed [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
        logic signed [DIV_W-1:0] remainder;
    } t_div_rsp;

    // Clamp a 72-bit signed value to 32 bits; bit 32 of the result flags a clamp.
    function automatic logic [32:0] sat72(input logic signed [71:0] v);
        logic [32:0] res;
        if (v > 72'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -72'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/piecewise_linear_sensor_calibration_unit.sv
// Top level of the piecewise-linear sensor calibration unit.
`default_nettype none

// A load beat writes one table entry in the cycle it is taken and never raises
// busy; its acknowledge appears on the next cycle, so loads stream one per cycle.
// A convert beat reads the two end entries and returns one on an exact match;
// else it walks the binary search one table read per cycle and, when interpolating,
// runs one division (none when the bracket ADC codes are equal) and states
// S_INT1 and S_INT2, or it streams every entry in use through a four-stage
// accumulate pipeline and runs seven divisions on the shared divider (four
// if the fit denominator is zero). Results are a one-cycle strobe with no
// back-pressure; the receiver must take every beat as it appears.
// Sums are sized for tables of up to 4096 entries.
module piecewise_linear_sensor_calibration_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_op,
    input  wire logic [6:0]         i_entry_index,
    input  wire logic signed [31:0] i_entry_pressure,
    input  wire logic [15:0]        i_entry_adc,
    input  wire logic [15:0]        i_adc_reading,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data,
    output logic                    o_strobe,
    output logic signed [31:0]      o_pressure_out,
    output logic [1:0]              o_result_kind,
    output logic                    o_fit_error
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] KIND_EXACT  = 2'd0;
    localparam logic [1:0] KIND_INTERP = 2'd1;
    localparam logic [1:0] KIND_EXTRAP = 2'd2;
    localparam logic [1:0] KIND_LOAD   = 2'd3;

    localparam logic OP_LOAD = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDL, S_CHK, S_SRCH, S_DIVS, S_DIVW, S_INT1, S_INT2,
        S_ACC, S_M1, S_M2, S_M3, S_EX1, S_EX2
    } t_state;

    typedef enum logic [2:0] {
        D_SLOPE_I, D_SXP, D_SX, D_SP, D_SXX, D_SLOPE_E, D_NUM, D_FRAC
    } t_dsel;

    // Table memories.
    logic signed [31:0] pmem [TABLE_DEPTH];
    logic [15:0]        amem [TABLE_DEPTH];
    logic signed [31:0] r_rd_p;
    logic [15:0]        r_rd_a;
    logic [AW-1:0]      n_raddr;
    logic               n_we;
    logic [AW-1:0]      n_waddr;

    t_state r_state;
    t_dsel  r_dsel;

    logic [7:0]         r_entry_count;
    logic [15:0]        r_rd;
    logic [AW-1:0]      r_last;
    logic [AW-1:0]      r_lo_i, r_hi_i, r_mid;
    logic [15:0]        r_lo_a, r_hi_a;
    logic signed [31:0] r_lo_p, r_hi_p;

    // Accumulate pipeline.
    logic [AW-1:0]      r_idx;
    logic               r_issue_done;
    logic [2:0]         r_pv;
    logic [62:0]        r_mp;
    logic               r_pneg;
    logic [15:0]        r_a1, r_a2;
    logic signed [41:0] r_ap;
    logic [31:0]        r_aa;
    logic signed [25:0] r_pp;
    logic signed [53:0] r_sum_ap;
    logic [27:0]        r_sum_a;
    logic signed [37:0] r_sum_p;
    logic [43:0]        r_sum_aa;

    // Means and fit terms.
    logic signed [41:0] r_m_ap;
    logic [15:0]        r_m_a;
    logic signed [25:0] r_m_p;
    logic [31:0]        r_m_aa;
    logic [31:0]        r_sxsx;
    logic signed [41:0] r_sxsp;
    logic signed [57:0] r_sxxsp;
    logic signed [57:0] r_sxsxp;
    logic signed [33:0] r_den;
    logic signed [49:0] r_sn;
    logic signed [58:0] r_num;
    logic signed [49:0] r_slope_e;
    logic signed [58:0] r_q;
    logic signed [33:0] r_r;
    logic signed [7:0]  r_t;
    logic signed [66:0] r_f1;
    logic signed [65:0] r_f2;

    // Interpolation.
    logic signed [33:0] r_slope_i;
    logic signed [50:0] r_iprod;

    logic               r_o_valid;
    logic signed [31:0] r_o_p;
    logic [1:0]         r_o_kind;
    logic               r_o_err;

    plsc_pkg::t_div_req div_req;
    plsc_pkg::t_div_rsp div_rsp;

    logic               accept;
    logic [NW-1:0]      n_active;
    logic [AW-1:0]      n_mid;
    logic [AW-1:0]      n_lo_i, n_hi_i;
    logic               issue;
    logic [25:0]        p_mag;
    logic signed [25:0] p_val;
    logic [31:0]        p_abs;
    logic [32:0]        sat_i, sat_e;

    assign accept      = start & ~busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_entry_count < 8'd2) begin
            n_active = NW'(2);
        end else if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
            n_active = NW'(TABLE_DEPTH);
        end else begin
            n_active = NW'(r_entry_count);
        end
    end

    assign n_we    = accept & (i_op == OP_LOAD) & (32'(i_entry_index) < 32'(TABLE_DEPTH));
    assign n_waddr = AW'(i_entry_index);

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            pmem[n_waddr] <= i_entry_pressure;
        end
        r_rd_p <= pmem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            amem[n_waddr] <= i_entry_adc;
        end
        r_rd_a <= amem[n_raddr];
    end

    // Search step, table read address and accumulate issue.
    always_comb begin
        n_lo_i  = r_lo_i;
        n_hi_i  = r_hi_i;
        n_raddr = '0;
        issue   = 1'b0;
        if (r_rd < r_rd_a) begin
            n_hi_i = r_mid;
        end else begin
            n_lo_i = r_mid;
        end
        n_mid = n_lo_i + ((n_hi_i - n_lo_i) >> 1);
        case (r_state)
            S_RDL:   n_raddr = r_last;
            S_CHK:   n_raddr = r_last >> 1;
            S_SRCH:  n_raddr = n_mid;
            S_ACC: begin
                n_raddr = r_idx;
                issue   = ~r_issue_done;
            end
            default: n_raddr = '0;
        endcase
    end

    always_comb begin
        div_req.start    = (r_state == S_DIVS);
        div_req.dividend = '0;
        div_req.divisor  = 64'sd1;
        unique case (r_dsel)
            D_SLOPE_I: begin
                div_req.dividend = 64'($signed({r_hi_p[31], r_hi_p}) -
                                       $signed({r_lo_p[31], r_lo_p}));
                div_req.divisor  = 64'($signed({1'b0, r_hi_a}) - $signed({1'b0, r_lo_a}));
            end
            D_SXP: begin
                div_req.dividend = 64'(r_sum_ap);
                div_req.divisor  = 64'(r_last) + 64'sd1;
            end
            D_SX: begin
                div_req.dividend = 64'(r_sum_a);
                div_req.divisor  = 64'(r_last) + 64'sd1;
            end
            D_SP: begin
                div_req.dividend = 64'(r_sum_p);
                div_req.divisor  = 64'(r_last) + 64'sd1;
            end
            D_SXX: begin
                div_req.dividend = 64'(r_sum_aa);
                div_req.divisor  = 64'(r_last) + 64'sd1;
            end
            D_SLOPE_E: begin
                div_req.dividend = 64'(r_sn);
                div_req.divisor  = 64'(r_den);
            end
            D_NUM: begin
                div_req.dividend = 64'(r_num);
                div_req.divisor  = 64'(r_den);
            end
            D_FRAC: begin
                div_req.dividend = 64'(r_r) * 64'(plsc_pkg::SCALE);
                div_req.divisor  = 64'(r_den);
            end
            default: begin
                div_req.dividend = '0;
                div_req.divisor  = 64'sd1;
            end
        endcase
    end

    plsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Pressure over 100, truncated toward zero, from the registered reciprocal product.
    assign p_abs = r_rd_p[31] ? 32'd0 - 32'(r_rd_p) : 32'(r_rd_p);
    assign p_mag = r_mp[plsc_pkg::DIV100_SHIFT+25:plsc_pkg::DIV100_SHIFT];
    assign p_val = r_pneg ? 26'sd0 - $signed(p_mag) : $signed(p_mag);

    assign sat_i = plsc_pkg::sat72(72'($signed({r_lo_p[31], r_lo_p})) + 72'(r_iprod));
    assign sat_e = plsc_pkg::sat72(72'(r_f1) + 72'(r_f2) + 72'(r_t));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_dsel        <= D_SLOPE_I;
            r_entry_count <= 8'd2;
            r_pv          <= '0;
            r_issue_done  <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_data;
            end
            r_o_valid <= 1'b0;
            r_pv      <= {r_pv[1:0], issue};

            if (r_pv[0]) begin
                r_mp   <= 63'(p_abs * plsc_pkg::DIV100_MAGIC);
                r_pneg <= r_rd_p[31];
                r_a1   <= r_rd_a;
            end
            if (r_pv[1]) begin
                r_ap <= 42'($signed({1'b0, r_a1}) * p_val);
                r_aa <= r_a1 * r_a1;
                r_pp <= p_val;
                r_a2 <= r_a1;
            end
            if (r_pv[2]) begin
                r_sum_ap <= r_sum_ap + 54'(r_ap);
                r_sum_a  <= r_sum_a + 28'(r_a2);
                r_sum_p  <= r_sum_p + 38'(r_pp);
                r_sum_aa <= r_sum_aa + 44'(r_aa);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_op == OP_LOAD) begin
                            r_o_valid <= 1'b1;
                            r_o_p     <= '0;
                            r_o_kind  <= KIND_LOAD;
                            r_o_err   <= 1'b0;
                        end else begin
                            r_rd    <= i_adc_reading;
                            r_last  <= AW'(n_active - 1'b1);
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: r_state <= S_RDL;
                S_RDL: begin
                    r_lo_a  <= r_rd_a;
                    r_lo_p  <= r_rd_p;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_hi_a <= r_rd_a;
                    r_hi_p <= r_rd_p;
                    r_lo_i <= '0;
                    r_hi_i <= r_last;
                    r_mid  <= r_last >> 1;
                    if (r_rd >= r_lo_a && r_rd <= r_rd_a) begin
                        if (r_rd == r_lo_a || r_rd == r_rd_a) begin
                            r_o_valid <= 1'b1;
                            r_o_p     <= (r_rd == r_lo_a) ? r_lo_p : r_rd_p;
                            r_o_kind  <= KIND_EXACT;
                            r_o_err   <= 1'b0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end else begin
                        r_idx        <= '0;
                        r_issue_done <= 1'b0;
                        r_sum_ap     <= '0;
                        r_sum_a      <= '0;
                        r_sum_p      <= '0;
                        r_sum_aa     <= '0;
                        r_state      <= S_ACC;
                    end
                end
                S_SRCH: begin
                    if (r_rd == r_rd_a) begin
                        r_o_valid <= 1'b1;
                        r_o_p     <= r_rd_p;
                        r_o_kind  <= KIND_EXACT;
                        r_o_err   <= 1'b0;
                        r_state   <= S_IDLE;
                    end else if (r_mid == r_lo_i) begin
                        if (r_hi_a == r_lo_a) begin
                            r_slope_i <= '0;
                            r_state   <= S_INT1;
                        end else begin
                            r_dsel  <= D_SLOPE_I;
                            r_state <= S_DIVS;
                        end
                    end else begin
                        if (r_rd < r_rd_a) begin
                            r_hi_a <= r_rd_a;
                            r_hi_p <= r_rd_p;
                        end else begin
                            r_lo_a <= r_rd_a;
                            r_lo_p <= r_rd_p;
                        end
                        r_lo_i <= n_lo_i;
                        r_hi_i <= n_hi_i;
                        r_mid  <= n_mid;
                    end
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_state <= S_DIVS;
                        unique case (r_dsel)
                            D_SLOPE_I: begin
                                r_slope_i <= div_rsp.quotient[33:0];
                                r_state   <= S_INT1;
                            end
                            D_SXP: begin
                                r_m_ap <= div_rsp.quotient[41:0];
                                r_dsel <= D_SX;
                            end
                            D_SX: begin
                                r_m_a  <= div_rsp.quotient[15:0];
                                r_dsel <= D_SP;
                            end
                            D_SP: begin
                                r_m_p  <= div_rsp.quotient[25:0];
                                r_dsel <= D_SXX;
                            end
                            D_SXX: begin
                                r_m_aa  <= div_rsp.quotient[31:0];
                                r_state <= S_M1;
                            end
                            D_SLOPE_E: begin
                                r_slope_e <= div_rsp.quotient[49:0];
                                r_dsel    <= D_NUM;
                            end
                            D_NUM: begin
                                r_q    <= div_rsp.quotient[58:0];
                                r_r    <= div_rsp.remainder[33:0];
                                r_dsel <= D_FRAC;
                            end
                            D_FRAC: begin
                                r_t     <= div_rsp.quotient[7:0];
                                r_state <= S_EX1;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_INT1: begin
                    r_iprod <= 51'(r_slope_i *
                                   ($signed({1'b0, r_rd}) - $signed({1'b0, r_lo_a})));
                    r_state <= S_INT2;
                end
                S_INT2: begin
                    r_o_valid <= 1'b1;
                    r_o_p     <= sat_i[31:0];
                    r_o_kind  <= KIND_INTERP;
                    r_o_err   <= sat_i[32];
                    r_state   <= S_IDLE;
                end
                S_ACC: begin
                    if (issue) begin
                        if (r_idx == r_last) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_issue_done && r_pv == 3'b000) begin
                        r_dsel  <= D_SXP;
                        r_state <= S_DIVS;
                    end
                end
                S_M1: begin
                    r_sxsx  <= r_m_a * r_m_a;
                    r_sxsp  <= 42'($signed({1'b0, r_m_a}) * r_m_p);
                    r_sxxsp <= 58'($signed({1'b0, r_m_aa}) * r_m_p);
                    r_sxsxp <= 58'($signed({1'b0, r_m_a}) * r_m_ap);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_den   <= $signed({2'b00, r_m_aa}) - $signed({2'b00, r_sxsx});
                    r_sn    <= 50'((43'(r_m_ap) - 43'(r_sxsp)) * 50'(plsc_pkg::SCALE));
                    r_num   <= 59'(r_sxxsp) - 59'(r_sxsxp);
                    r_state <= S_M3;
                end
                S_M3: begin
                    if (r_den == '0) begin
                        r_o_valid <= 1'b1;
                        r_o_p     <= '0;
                        r_o_kind  <= KIND_EXTRAP;
                        r_o_err   <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_dsel  <= D_SLOPE_E;
                        r_state <= S_DIVS;
                    end
                end
                S_EX1: begin
                    r_f1    <= 67'(r_slope_e * $signed({1'b0, r_rd}));
                    r_f2    <= 66'(r_q) * 66'(plsc_pkg::SCALE);
                    r_state <= S_EX2;
                end
                S_EX2: begin
                    r_o_valid <= 1'b1;
                    r_o_p     <= sat_e[31:0];
                    r_o_kind  <= KIND_EXTRAP;
                    r_o_err   <= sat_e[32];
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe       = r_o_valid;
    assign o_pressure_out = r_o_p;
    assign o_result_kind  = r_o_kind;
    assign o_fit_error    = r_o_err;

endmodule

`default_nettype wire

// File: hw/rtl/plsc_div.sv
// Shared radix-2 signed divider with truncation toward zero.
`default_nettype none

module plsc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire plsc_pkg::t_div_req i_req,
    output plsc_pkg::t_div_rsp      o_rsp
);

    localparam int W     = plsc_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;
    logic             r_qneg;
    logic             r_rneg;

    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             ge;

    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = ~diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_cnt  <= CNT_W'(W);
                r_rem  <= '0;
                r_quo  <= i_req.dividend[W-1] ? W'(0) - i_req.dividend : i_req.dividend;
                r_dvs  <= i_req.divisor[W-1] ? W'(0) - i_req.divisor : i_req.divisor;
                r_qneg <= i_req.dividend[W-1] ^ i_req.divisor[W-1];
                r_rneg <= i_req.dividend[W-1];
            end else if (r_run) begin
                r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
                r_quo <= {r_quo[W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_qneg ? W'(0) - r_quo : r_quo;
    assign o_rsp.remainder = r_rneg ? W'(0) - r_rem : r_rem;

endmodule

`default_nettype wire
